### hw/rtl/table_driven_moore_acceptor_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the table driven acceptor
// Immediate-implication and next-cycle-implication property wrappers.
// ---------------------------------------------------------------------------
`ifndef TABLE_DRIVEN_MOORE_ACCEPTOR_DEFINES_SVH
`define TABLE_DRIVEN_MOORE_ACCEPTOR_DEFINES_SVH

// Check cons in the same cycle as ante.
`define TDMA_ASSERT_NOW(label, rst, ante, cons) \
   label: assert property (@(posedge clock) disable iff (rst) (ante) |-> (cons)) \
      else $error("tdma: same-cycle check failed");

// Check cons in the cycle after ante.
`define TDMA_ASSERT_NEXT(label, rst, ante, cons) \
   label: assert property (@(posedge clock) disable iff (rst) (ante) |=> (cons)) \
      else $error("tdma: next-cycle check failed");

`endif

### hw/rtl/tdma_pkg.sv
// ---------------------------------------------------------------------------
// tdma_pkg
// Field widths, opcodes, register indexes and shared types of the acceptor.
// ---------------------------------------------------------------------------
package tdma_pkg;

   localparam int OP_W       = 2;
   localparam int STATE_W    = 7;
   localparam int SYM_W      = 8;
   localparam int CODE_W     = 8;
   localparam int TRUSE_W    = 8;
   localparam int CSR_AW     = 3;
   localparam int CSR_DW     = 32;
   localparam int STATE_SPAN = 1 << STATE_W;

   localparam logic [OP_W-1:0] OP_LOAD_TRANS = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD_STATE = 2'd1;
   localparam logic [OP_W-1:0] OP_START      = 2'd2;
   localparam logic [OP_W-1:0] OP_SYMBOL     = 2'd3;

   localparam logic REG_INITIAL_STATE = 1'b0;
   localparam logic REG_TRANS_IN_USE  = 1'b1;

   typedef struct packed {
      logic [STATE_W-1:0] initial_state;
      logic [TRUSE_W-1:0] trans_in_use;
   } cfg_type;

   typedef struct packed {
      logic [STATE_W-1:0] source;
      logic [STATE_W-1:0] dest;
      logic [SYM_W-1:0]   symbol;
   } trans_entry_type;

   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic              is_final;
   } state_entry_type;

endpackage

### hw/rtl/tdma_req_if.sv
// ---------------------------------------------------------------------------
// tdma_req_if
// Request channel: load, start and symbol transactions.
// ---------------------------------------------------------------------------
interface tdma_req_if;
   logic                         valid;
   logic                         ready;
   logic [tdma_pkg::OP_W-1:0]    opcode;
   logic [tdma_pkg::STATE_W-1:0] table_index;
   logic [tdma_pkg::STATE_W-1:0] source_state;
   logic [tdma_pkg::STATE_W-1:0] dest_state;
   logic [tdma_pkg::SYM_W-1:0]   symbol;
   logic [tdma_pkg::CODE_W-1:0]  state_output;
   logic                         state_is_final;
   logic                         last_of_string;

   modport source (
      output valid, opcode, table_index, source_state, dest_state, symbol,
             state_output, state_is_final, last_of_string,
      input  ready
   );

   modport sink (
      input  valid, opcode, table_index, source_state, dest_state, symbol,
             state_output, state_is_final, last_of_string,
      output ready
   );
endinterface

### hw/rtl/tdma_rsp_if.sv
// ---------------------------------------------------------------------------
// tdma_rsp_if
// Response channel: present state, its output code and the verdict.
// ---------------------------------------------------------------------------
interface tdma_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [tdma_pkg::STATE_W-1:0] state_number;
   logic [tdma_pkg::CODE_W-1:0]  output_code;
   logic                         moved;
   logic                         dead;
   logic                         verdict_valid;
   logic                         accepted;

   modport source (
      output valid, state_number, output_code, moved, dead, verdict_valid, accepted,
      input  ready
   );

   modport sink (
      input  valid, state_number, output_code, moved, dead, verdict_valid, accepted,
      output ready
   );
endinterface

### hw/rtl/tdma_csr.sv
// ---------------------------------------------------------------------------
// tdma_csr
// APB-style register file: initial state and search length.
// ---------------------------------------------------------------------------
module tdma_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [tdma_pkg::CSR_AW-1:0] paddr,
   input  logic [tdma_pkg::CSR_DW-1:0] pwdata,
   output logic [tdma_pkg::CSR_DW-1:0] prdata,
   output logic                        pready,
   output tdma_pkg::cfg_type           cfg
);

   tdma_pkg::cfg_type cfg_ff;
   tdma_pkg::cfg_type cfg_in;
   logic              wr_fire;
   logic              reg_sel;

   assign pready  = 1'b1;
   assign wr_fire = psel && penable && pwrite;
   assign reg_sel = paddr[2];
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_fire) begin
         case (reg_sel)
            tdma_pkg::REG_INITIAL_STATE: begin
               cfg_in.initial_state = pwdata[tdma_pkg::STATE_W-1:0];
            end
            tdma_pkg::REG_TRANS_IN_USE: begin
               cfg_in.trans_in_use = pwdata[tdma_pkg::TRUSE_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         tdma_pkg::REG_INITIAL_STATE: prdata = tdma_pkg::CSR_DW'(cfg_ff.initial_state);
         tdma_pkg::REG_TRANS_IN_USE:  prdata = tdma_pkg::CSR_DW'(cfg_ff.trans_in_use);
         default:                     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### hw/rtl/tdma_trans_mem.sv
// ---------------------------------------------------------------------------
// tdma_trans_mem
// Transition table: one write port, one registered read port.
// ---------------------------------------------------------------------------
module tdma_trans_mem #(
   parameter int DEPTH = 128,
   parameter int AW    = 7
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [AW-1:0]             wr_addr,
   input  tdma_pkg::trans_entry_type wr_data,
   input  logic [AW-1:0]             rd_addr,
   output tdma_pkg::trans_entry_type rd_data
);

   tdma_pkg::trans_entry_type mem [DEPTH];
   tdma_pkg::trans_entry_type rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

### hw/rtl/tdma_state_mem.sv
// ---------------------------------------------------------------------------
// tdma_state_mem
// State table: output codes and final marks, registered read.
// ---------------------------------------------------------------------------
module tdma_state_mem #(
   parameter int DEPTH = 128,
   parameter int AW    = 7
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      wr_en,
   input  logic [AW-1:0]             wr_addr,
   input  tdma_pkg::state_entry_type wr_data,
   input  logic [AW-1:0]             rd_addr,
   output tdma_pkg::state_entry_type rd_data
);

   tdma_pkg::state_entry_type mem [DEPTH];
   tdma_pkg::state_entry_type rd_entry_ff;
   logic [DEPTH-1:0]          valid_ff;
   logic [DEPTH-1:0]          valid_in;
   logic                      rd_valid_ff;

   // A never-written state reads as not final.
   assign rd_data.code     = rd_entry_ff.code;
   assign rd_data.is_final = rd_entry_ff.is_final && rd_valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_entry_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

endmodule

### hw/rtl/table_driven_moore_acceptor.sv
// ---------------------------------------------------------------------------
// table_driven_moore_acceptor: programmable Moore machine with string verdict
// Loads are written on acceptance. Start: the result passes READ and FORM.
// Symbol: SCAN, READ, FORM; the scan reads n = min(transitions_in_use, table
// depth) entries at one entry per cycle, ending at a hit; dead symbols skip it.
// Reset clears control, registers and final marks at once; no clearing pass.
// ---------------------------------------------------------------------------
`include "table_driven_moore_acceptor_defines.svh"

module table_driven_moore_acceptor #(
   parameter int MAX_STATES      = 128,
   parameter int MAX_TRANSITIONS = 128
) (
   input  logic                        clock,
   input  logic                        reset,
   tdma_req_if.sink                    req_ch,
   tdma_rsp_if.source                  rsp_ch,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [tdma_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [tdma_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [tdma_pkg::CSR_DW-1:0] csr_prdata,
   output logic                        csr_pready
);

   // Only indexes reachable by the table_index field get storage.
   localparam int TR_DEPTH = (MAX_TRANSITIONS < tdma_pkg::STATE_SPAN) ?
                             MAX_TRANSITIONS : tdma_pkg::STATE_SPAN;
   localparam int ST_DEPTH = (MAX_STATES < tdma_pkg::STATE_SPAN) ?
                             MAX_STATES : tdma_pkg::STATE_SPAN;
   localparam int TR_AW    = (TR_DEPTH > 1) ? $clog2(TR_DEPTH) : 1;
   localparam int ST_AW    = $clog2(ST_DEPTH);
   localparam int CNT_W    = $clog2(TR_DEPTH + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_READ = 2'd2;
   localparam logic [1:0] S_FORM = 2'd3;

   tdma_pkg::cfg_type          cfg;
   tdma_pkg::trans_entry_type  tr_wr_data;
   tdma_pkg::trans_entry_type  tr_rd_data;
   tdma_pkg::state_entry_type  st_wr_data;
   tdma_pkg::state_entry_type  st_rd_data;

   logic [1:0]                   state_ff, state_in;
   logic [tdma_pkg::STATE_W-1:0] present_ff, present_in;
   logic                         dead_ff, dead_in;
   logic                         moved_ff, moved_in;
   logic                         last_ff, last_in;
   logic [tdma_pkg::SYM_W-1:0]   sym_ff, sym_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic [CNT_W-1:0]             limit_ff, limit_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [tdma_pkg::STATE_W-1:0] rsp_state_ff, rsp_state_in;
   logic [tdma_pkg::CODE_W-1:0]  rsp_code_ff, rsp_code_in;
   logic                         rsp_moved_ff, rsp_moved_in;
   logic                         rsp_dead_ff, rsp_dead_in;
   logic                         rsp_verdict_ff, rsp_verdict_in;
   logic                         rsp_accepted_ff, rsp_accepted_in;

   logic                         req_accept;
   logic                         tr_wr_en;
   logic                         st_wr_en;
   logic [TR_AW-1:0]             tr_rd_addr;
   logic [CNT_W-1:0]             cnt_nxt;
   logic [CNT_W-1:0]             limit_w;
   logic                         hit;
   logic                         state_in_range;
   logic                         state_final;
   logic [tdma_pkg::CODE_W-1:0]  state_code;

   tdma_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_accept   = req_ch.valid && req_ch.ready;

   assign tr_wr_en = req_accept && (req_ch.opcode == tdma_pkg::OP_LOAD_TRANS) &&
                     (32'(req_ch.table_index) < TR_DEPTH);
   assign st_wr_en = req_accept && (req_ch.opcode == tdma_pkg::OP_LOAD_STATE) &&
                     (32'(req_ch.table_index) < ST_DEPTH);

   assign tr_wr_data.source   = req_ch.source_state;
   assign tr_wr_data.dest     = req_ch.dest_state;
   assign tr_wr_data.symbol   = req_ch.symbol;
   assign st_wr_data.code     = req_ch.state_output;
   assign st_wr_data.is_final = req_ch.state_is_final;

   // Prefetch the next entry while the current one is compared.
   assign cnt_nxt    = cnt_ff + CNT_W'(1);
   assign tr_rd_addr = (state_ff == S_SCAN) ? cnt_nxt[TR_AW-1:0] : '0;

   tdma_trans_mem #(
      .DEPTH (TR_DEPTH),
      .AW    (TR_AW)
   ) u_trans_mem (
      .clock   (clock),
      .wr_en   (tr_wr_en),
      .wr_addr (TR_AW'(req_ch.table_index)),
      .wr_data (tr_wr_data),
      .rd_addr (tr_rd_addr),
      .rd_data (tr_rd_data)
   );

   tdma_state_mem #(
      .DEPTH (ST_DEPTH),
      .AW    (ST_AW)
   ) u_state_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (st_wr_en),
      .wr_addr (ST_AW'(req_ch.table_index)),
      .wr_data (st_wr_data),
      .rd_addr (ST_AW'(present_ff)),
      .rd_data (st_rd_data)
   );

   // Saturate the search length at the table depth.
   assign limit_w = (32'(cfg.trans_in_use) > TR_DEPTH) ? CNT_W'(TR_DEPTH) :
                                                         CNT_W'(cfg.trans_in_use);

   // Compare unit: source state and symbol match.
   assign hit = (tr_rd_data.source == present_ff) && (tr_rd_data.symbol == sym_ff);

   assign state_in_range = (32'(present_ff) < ST_DEPTH);
   assign state_code     = state_in_range ? st_rd_data.code : '0;
   assign state_final    = state_in_range && st_rd_data.is_final;

   always_comb begin
      state_in        = state_ff;
      present_in      = present_ff;
      dead_in         = dead_ff;
      moved_in        = moved_ff;
      last_in         = last_ff;
      sym_in          = sym_ff;
      cnt_in          = cnt_ff;
      limit_in        = limit_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ch.ready;
      rsp_state_in    = rsp_state_ff;
      rsp_code_in     = rsp_code_ff;
      rsp_moved_in    = rsp_moved_ff;
      rsp_dead_in     = rsp_dead_ff;
      rsp_verdict_in  = rsp_verdict_ff;
      rsp_accepted_in = rsp_accepted_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               case (req_ch.opcode)
                  tdma_pkg::OP_START: begin
                     present_in = cfg.initial_state;
                     dead_in    = 1'b0;
                     moved_in   = 1'b1;
                     last_in    = req_ch.last_of_string;
                     state_in   = S_READ;
                  end
                  tdma_pkg::OP_SYMBOL: begin
                     moved_in = 1'b0;
                     last_in  = req_ch.last_of_string;
                     sym_in   = req_ch.symbol;
                     if (dead_ff || (limit_w == '0)) begin
                        dead_in  = 1'b1;
                        state_in = S_READ;
                     end else begin
                        cnt_in   = '0;
                        limit_in = limit_w;
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (hit) begin
               present_in = tr_rd_data.dest;
               moved_in   = 1'b1;
               state_in   = S_READ;
            end else if (cnt_nxt == limit_ff) begin
               dead_in  = 1'b1;
               state_in = S_READ;
            end else begin
               cnt_in = cnt_nxt;
            end
         end
         S_READ: begin
            state_in = S_FORM;
         end
         S_FORM: begin
            // Hold until the output register is free.
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in    = 1'b1;
               rsp_state_in    = present_ff;
               rsp_code_in     = state_code;
               rsp_moved_in    = moved_ff;
               rsp_dead_in     = dead_ff;
               rsp_verdict_in  = last_ff;
               rsp_accepted_in = last_ff && !dead_ff && state_final;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         present_ff   <= '0;
         dead_ff      <= 1'b0;
         moved_ff     <= 1'b0;
         last_ff      <= 1'b0;
         cnt_ff       <= '0;
         limit_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         present_ff   <= present_in;
         dead_ff      <= dead_in;
         moved_ff     <= moved_in;
         last_ff      <= last_in;
         cnt_ff       <= cnt_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff          <= sym_in;
      rsp_state_ff    <= rsp_state_in;
      rsp_code_ff     <= rsp_code_in;
      rsp_moved_ff    <= rsp_moved_in;
      rsp_dead_ff     <= rsp_dead_in;
      rsp_verdict_ff  <= rsp_verdict_in;
      rsp_accepted_ff <= rsp_accepted_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.state_number  = rsp_state_ff;
   assign rsp_ch.output_code   = rsp_code_ff;
   assign rsp_ch.moved         = rsp_moved_ff;
   assign rsp_ch.dead          = rsp_dead_ff;
   assign rsp_ch.verdict_valid = rsp_verdict_ff;
   assign rsp_ch.accepted      = rsp_accepted_ff;

   `TDMA_ASSERT_NOW(a_scan_bound, reset, state_ff == S_SCAN, cnt_ff < limit_ff)
   `TDMA_ASSERT_NEXT(a_dead_skip, reset, req_accept && (req_ch.opcode == tdma_pkg::OP_SYMBOL) && dead_ff, (state_ff == S_READ) && !moved_ff && dead_ff)
   `TDMA_ASSERT_NOW(a_verdict, reset, rsp_ch.valid && rsp_ch.accepted, rsp_ch.verdict_valid && !rsp_ch.dead)

endmodule

### verif/tdma_acceptor_checker.sv
// ---------------------------------------------------------------------------
// tdma_acceptor_checker
// Watches the request, response and register ports of the table driven
// acceptor, predicts each response from its own copy of the tables, the
// present state and the registers, and compares every response in order.
// ---------------------------------------------------------------------------
module tdma_acceptor_checker (
   input  logic                        clock,
   input  logic                        reset,
   tdma_req_if                         req_mon,
   tdma_rsp_if                         rsp_mon,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [tdma_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [tdma_pkg::CSR_DW-1:0] csr_pwdata,
   input  logic                        csr_pready,
   output int                          error_count,
   output int                          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH = tdma_pkg::STATE_SPAN;

   typedef logic [tdma_pkg::STATE_W-1:0] state_num_type;
   typedef logic [tdma_pkg::SYM_W-1:0]   sym_type;
   typedef logic [tdma_pkg::CODE_W-1:0]  code_type;

   typedef struct packed {
      state_num_type state_number;
      code_type      output_code;
      logic          moved;
      logic          dead;
      logic          verdict_valid;
      logic          accepted;
   } acceptor_result_type;

   state_num_type                 trans_source [TABLE_DEPTH];
   state_num_type                 trans_dest   [TABLE_DEPTH];
   sym_type                       trans_symbol [TABLE_DEPTH];
   code_type                      state_code   [TABLE_DEPTH];
   logic                          state_final  [TABLE_DEPTH];
   state_num_type                 present_state;
   logic                          string_dead;
   state_num_type                 initial_reg;
   logic [tdma_pkg::TRUSE_W-1:0]  in_use_reg;
   acceptor_result_type           pending_results[$];
   int                            mismatches = 0;
   int                            waiting = 0;

   assign error_count   = mismatches;
   assign pending_count = waiting;

   // Apply one request to the model; return 1 when it yields a response.
   function automatic bit step_acceptor(input logic [tdma_pkg::OP_W-1:0] op,
                                        input state_num_type idx,
                                        input state_num_type src,
                                        input state_num_type dst,
                                        input sym_type sym, input code_type code,
                                        input logic fin, input logic last,
                                        output acceptor_result_type res);
      int limit;
      bit hit;
      hit = 1'b0;
      res = '0;
      case (op)
         tdma_pkg::OP_LOAD_TRANS: begin
            trans_source[idx] = src;
            trans_dest[idx]   = dst;
            trans_symbol[idx] = sym;
            return 1'b0;
         end
         tdma_pkg::OP_LOAD_STATE: begin
            state_code[idx]  = code;
            state_final[idx] = fin;
            return 1'b0;
         end
         tdma_pkg::OP_START: begin
            present_state = initial_reg;
            string_dead   = 1'b0;
            hit           = 1'b1;
         end
         tdma_pkg::OP_SYMBOL: begin
            if (!string_dead) begin
               // search length saturates at the table depth
               limit = (int'(in_use_reg) > TABLE_DEPTH) ? TABLE_DEPTH : int'(in_use_reg);
               for (int j = 0; j < limit && !hit; j++) begin
                  if (trans_source[j] == present_state && trans_symbol[j] == sym) begin
                     present_state = trans_dest[j];
                     hit           = 1'b1;
                  end
               end
               if (!hit) string_dead = 1'b1;
            end
         end
         default: begin
            return 1'b0;
         end
      endcase
      res.state_number  = present_state;
      res.output_code   = state_code[present_state];
      res.moved         = hit;
      res.dead          = string_dead;
      res.verdict_valid = last;
      res.accepted      = last && !string_dead && state_final[present_state];
      return 1'b1;
   endfunction

   initial begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         trans_source[i] = '0;
         trans_dest[i]   = '0;
         trans_symbol[i] = '0;
         state_code[i]   = '0;
         state_final[i]  = 1'b0;
      end
   end

   always @(posedge clock) begin : watch
      acceptor_result_type predicted;
      acceptor_result_type observed;
      if (reset) begin
         for (int i = 0; i < TABLE_DEPTH; i++) state_final[i] = 1'b0;
         present_state = '0;
         string_dead   = 1'b0;
         initial_reg   = '0;
         in_use_reg    = '0;
         pending_results.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[tdma_pkg::CSR_AW-1:2] == tdma_pkg::REG_INITIAL_STATE)
               initial_reg = csr_pwdata[tdma_pkg::STATE_W-1:0];
            else
               in_use_reg = csr_pwdata[tdma_pkg::TRUSE_W-1:0];
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            observed.state_number  = rsp_mon.state_number;
            observed.output_code   = rsp_mon.output_code;
            observed.moved         = rsp_mon.moved;
            observed.dead          = rsp_mon.dead;
            observed.verdict_valid = rsp_mon.verdict_valid;
            observed.accepted      = rsp_mon.accepted;
            if (pending_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: response with nothing outstanding: state %0d code %0h",
                           $realtime, observed.state_number, observed.output_code);
            end else begin
               predicted = pending_results.pop_front();
               if (observed.state_number  !== predicted.state_number  ||
                   observed.output_code   !== predicted.output_code   ||
                   observed.moved         !== predicted.moved         ||
                   observed.dead          !== predicted.dead          ||
                   observed.verdict_valid !== predicted.verdict_valid ||
                   observed.accepted      !== predicted.accepted) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"%0t: response mismatch: exp state %0d code %0h moved %0b ",
                               "dead %0b verdict %0b acc %0b / got state %0d code %0h ",
                               "moved %0b dead %0b verdict %0b acc %0b"}, $realtime,
                              predicted.state_number, predicted.output_code,
                              predicted.moved, predicted.dead, predicted.verdict_valid,
                              predicted.accepted, observed.state_number,
                              observed.output_code, observed.moved, observed.dead,
                              observed.verdict_valid, observed.accepted);
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (step_acceptor(req_mon.opcode, req_mon.table_index, req_mon.source_state,
                              req_mon.dest_state, req_mon.symbol, req_mon.state_output,
                              req_mon.state_is_final, req_mon.last_of_string, predicted))
               pending_results.push_back(predicted);
         end
      end
      waiting = pending_results.size();
   end
endmodule

### verif/tb_table_driven_moore_acceptor.sv
// ---------------------------------------------------------------------------
// tb_table_driven_moore_acceptor
// Loads transition and state tables, runs strings of symbols under several
// register settings with bursty requests and a stalling response sink, and
// reports the verdict from the checker's error and outstanding counts.
// ---------------------------------------------------------------------------
module tb_table_driven_moore_acceptor;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  ITEM_TARGET = 1900;
   localparam int  POOL_SIZE   = 6;
   localparam int  ALPHA_SIZE  = 3;
   localparam int  COVER_SIZE  = POOL_SIZE * ALPHA_SIZE;
   localparam real TIMEOUT_NS  = 20_000_000.0;

   typedef logic [tdma_pkg::STATE_W-1:0] state_num_type;
   typedef logic [tdma_pkg::SYM_W-1:0]   sym_type;
   typedef logic [tdma_pkg::CODE_W-1:0]  code_type;

   logic                        clock;
   logic                        reset;
   logic                        csr_psel;
   logic                        csr_penable;
   logic                        csr_pwrite;
   logic [tdma_pkg::CSR_AW-1:0] csr_paddr;
   logic [tdma_pkg::CSR_DW-1:0] csr_pwdata;
   logic [tdma_pkg::CSR_DW-1:0] csr_prdata;
   logic                        csr_pready;
   int                          error_count;
   int                          pending_count;
   int                          items_sent = 0;
   int                          burst_left = 0;
   state_num_type               pool     [POOL_SIZE];
   sym_type                     alphabet [ALPHA_SIZE];

   tdma_req_if req_ch ();
   tdma_rsp_if rsp_ch ();

   table_driven_moore_acceptor dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   tdma_acceptor_checker acceptor_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_pready    (csr_pready),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("tb_table_driven_moore_acceptor: done, errors");
      $finish;
   end

   // Response sink: most frames hold a stall window and jitter; the rest never stall.
   initial begin
      int slot;
      int win_start;
      int win_len;
      slot      = 0;
      win_start = 0;
      win_len   = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (slot == 0) begin
            win_len   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 24);
            win_start = $urandom_range(0, 39);
         end
         rsp_ch.ready <= !(slot >= win_start && slot < win_start + win_len) &&
                         (win_len == 0 || $urandom_range(0, 7) != 0);
         slot = (slot + 1) % 64;
      end
   end

   task automatic send_item(input logic [tdma_pkg::OP_W-1:0] op, input state_num_type idx,
                            input state_num_type src, input state_num_type dst,
                            input sym_type sym, input code_type code,
                            input logic fin, input logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid          <= 1'b1;
      req_ch.opcode         <= op;
      req_ch.table_index    <= idx;
      req_ch.source_state   <= src;
      req_ch.dest_state     <= dst;
      req_ch.symbol         <= sym;
      req_ch.state_output   <= code;
      req_ch.state_is_final <= fin;
      req_ch.last_of_string <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic load_transition(input state_num_type entry, input state_num_type src,
                                  input state_num_type dst, input sym_type sym);
      send_item(tdma_pkg::OP_LOAD_TRANS, entry, src, dst, sym, code_type'($urandom),
                1'($urandom), 1'($urandom));
   endtask

   task automatic load_state(input state_num_type s, input code_type code, input logic fin);
      send_item(tdma_pkg::OP_LOAD_STATE, s, state_num_type'($urandom),
                state_num_type'($urandom), sym_type'($urandom), code, fin, 1'($urandom));
   endtask

   task automatic start_string(input logic last);
      send_item(tdma_pkg::OP_START, state_num_type'($urandom), state_num_type'($urandom),
                state_num_type'($urandom), sym_type'($urandom), code_type'($urandom),
                1'($urandom), last);
   endtask

   task automatic feed_symbol(input sym_type sym, input logic last);
      send_item(tdma_pkg::OP_SYMBOL, state_num_type'($urandom), state_num_type'($urandom),
                state_num_type'($urandom), sym, code_type'($urandom), 1'($urandom), last);
   endtask

   // Hold requests until every response is in, then let loads settle.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      do @(negedge clock); while (pending_count != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input logic reg_sel, input int value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_sel, 2'b00};
      csr_pwdata  <= tdma_pkg::CSR_DW'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   function automatic sym_type pick_symbol();
      if ($urandom_range(0, 7) == 0) return sym_type'($urandom);
      return alphabet[$urandom_range(0, ALPHA_SIZE - 1)];
   endfunction

   function automatic state_num_type pick_state(input int stray_odds);
      if ($urandom_range(0, stray_odds - 1) == 0) return state_num_type'($urandom);
      return pool[$urandom_range(0, POOL_SIZE - 1)];
   endfunction

   // Build a machine on a small pool of states: entries up front cover every pool
   // state and alphabet symbol; such pairs hit when enough entries are searched.
   task automatic build_machine(input state_num_type init, input bit fill_all);
      int pair_order[COVER_SIZE];
      int swap_at;
      int tmp;
      int last_entry;
      pool[0] = init;
      for (int i = 1; i < POOL_SIZE; i++) pool[i] = state_num_type'($urandom);
      for (int i = 0; i < ALPHA_SIZE; i++) alphabet[i] = sym_type'($urandom);
      if (fill_all) begin
         alphabet[0] = '0;
         alphabet[1] = '1;
         for (int s = 0; s < tdma_pkg::STATE_SPAN; s++)
            load_state(state_num_type'(s),
                       (s == 0) ? '1 : (s == tdma_pkg::STATE_SPAN - 1) ? '0 :
                                                                  code_type'($urandom),
                       1'($urandom));
      end else begin
         for (int i = 0; i < POOL_SIZE; i++)
            load_state(pool[i], code_type'($urandom), 1'($urandom));
      end
      for (int i = 0; i < COVER_SIZE; i++) pair_order[i] = i;
      for (int i = COVER_SIZE - 1; i > 0; i--) begin
         swap_at             = $urandom_range(0, i);
         tmp                 = pair_order[i];
         pair_order[i]       = pair_order[swap_at];
         pair_order[swap_at] = tmp;
      end
      for (int k = 0; k < COVER_SIZE; k++)
         load_transition(state_num_type'(k), pool[pair_order[k] / ALPHA_SIZE],
                         pick_state(16), alphabet[pair_order[k] % ALPHA_SIZE]);
      last_entry = fill_all ? tdma_pkg::STATE_SPAN - 1 : COVER_SIZE + $urandom_range(0, 30);
      for (int k = COVER_SIZE; k <= last_entry; k++)
         load_transition(state_num_type'(k), pick_state(8), pick_state(8), pick_symbol());
   endtask

   // Mostly well-formed strings; some skip the start, drop the last mark,
   // or rewrite a state in the middle.
   task automatic run_strings(input int budget);
      int stop_at;
      int len;
      stop_at = items_sent + budget;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 39) == 0) wait_drained();
         len = $urandom_range(0, 10);
         if ($urandom_range(0, 19) != 0) start_string(len == 0);
         for (int k = 1; k <= len; k++) begin
            if ($urandom_range(0, 24) == 0)
               load_state(pool[$urandom_range(0, POOL_SIZE - 1)], code_type'($urandom),
                          1'($urandom));
            feed_symbol(pick_symbol(), k == len && $urandom_range(0, 11) != 0);
         end
      end
   endtask

   initial begin
      state_num_type init;
      int            in_use;
      int            phase;
      reset                 <= 1'b1;
      req_ch.valid          <= 1'b0;
      req_ch.opcode         <= tdma_pkg::OP_LOAD_TRANS;
      req_ch.table_index    <= '0;
      req_ch.source_state   <= '0;
      req_ch.dest_state     <= '0;
      req_ch.symbol         <= '0;
      req_ch.state_output   <= '0;
      req_ch.state_is_final <= 1'b0;
      req_ch.last_of_string <= 1'b0;
      csr_psel              <= 1'b0;
      csr_penable           <= 1'b0;
      csr_pwrite            <= 1'b0;
      csr_paddr             <= '0;
      csr_pwdata            <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Registers still at reset: initial state 0, nothing searched.
      build_machine('0, 1'b1);
      feed_symbol(alphabet[0], 1'b0);   // symbol with no start, no entries searched
      feed_symbol(alphabet[1], 1'b1);   // symbol while dead, with verdict
      start_string(1'b1);               // empty string
      wait_drained();
      csr_write(tdma_pkg::REG_TRANS_IN_USE, tdma_pkg::STATE_SPAN);
      feed_symbol(alphabet[2], 1'b0);
      start_string(1'b0);
      feed_symbol(alphabet[0], 1'b0);
      feed_symbol(alphabet[1], 1'b0);
      feed_symbol(alphabet[2], 1'b1);
      start_string(1'b0);
      feed_symbol(~alphabet[2], 1'b0);
      feed_symbol(alphabet[0], 1'b0);
      feed_symbol(alphabet[1], 1'b1);
      wait_drained();
      // search length above the table size
      csr_write(tdma_pkg::REG_TRANS_IN_USE, 255);
      start_string(1'b0);
      feed_symbol(alphabet[1], 1'b0);
      feed_symbol(alphabet[0], 1'b1);
      run_strings(120);

      phase = 1;
      while (items_sent < ITEM_TARGET) begin
         init = state_num_type'($urandom);
         case (phase)
            1:       begin init = '1; in_use = 255; end
            2:       in_use = 1;
            3:       in_use = COVER_SIZE;
            4:       begin init = '0; in_use = 0; end
            5:       in_use = tdma_pkg::STATE_SPAN;
            default: in_use = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                          : $urandom_range(COVER_SIZE, 128);
         endcase
         wait_drained();
         csr_write(tdma_pkg::REG_INITIAL_STATE, int'(init));
         csr_write(tdma_pkg::REG_TRANS_IN_USE, in_use);
         build_machine(init, 1'b0);
         run_strings((phase == 4) ? 60 : 250);
         phase++;
      end

      wait_drained();
      repeat (20) @(posedge clock);
      @(negedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("tb_table_driven_moore_acceptor: done, clean");
      end else begin
         $display("tb_table_driven_moore_acceptor: done, errors");
      end
      $finish;
   end
endmodule
